FILE: sv/fmrc_pkg.sv
// Shared constants, codes and types of the first-match flow rule classifier.
package fmrc_pkg;

  localparam int RULE_SLOTS = 256;
  localparam int SLOT_W     = $clog2(RULE_SLOTS);
  localparam int IDX_W      = 8;
  localparam int CMP_W      = ((SLOT_W > IDX_W) ? SLOT_W : IDX_W) + 1;
  localparam int FUNC_W     = 2;
  localparam int ACT_W      = 2;
  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 6;
  localparam int PORT_W     = 16;
  localparam int CNT_W      = 32;

  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  localparam logic [ACT_W-1:0] ACT_INVALID = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ACCEPT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DROP    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RSVD    = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  index;
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] src_addr;
    logic [LEN_W-1:0]  src_len;
    logic [ADDR_W-1:0] dst_addr;
    logic [LEN_W-1:0]  dst_len;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
  } req_t;

  typedef struct packed {
    logic [ACT_W-1:0] verdict;
    logic             rule_hit;
    logic [IDX_W-1:0] hit_index;
    logic [CNT_W-1:0] hit_count;
  } res_t;

  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_ZERO,
    ADDR_NEXT
  } addr_sel_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_WRITE,
    RES_READ,
    RES_DEFAULT,
    RES_HIT
  } res_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic      req_load;
    logic      rule_wr;
    logic      cnt_wr;
    addr_sel_t addr_sel;
    logic      res_load;
    res_sel_t  res_sel;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              in_range;
    logic              ent_valid;
    logic              ent_match;
    logic              last_slot;
    logic              out_free;
  } stat_t;

endpackage

FILE: sv/fmrc_if.sv
// Request and result channel interfaces of the flow rule classifier.
interface fmrc_req_if;
  import fmrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  index;
  logic [ACT_W-1:0]  action;
  logic [ADDR_W-1:0] src_addr;
  logic [LEN_W-1:0]  src_len;
  logic [ADDR_W-1:0] dst_addr;
  logic [LEN_W-1:0]  dst_len;
  logic [PORT_W-1:0] src_port;
  logic [PORT_W-1:0] dst_port;

  modport source (
    output valid, func, index, action, src_addr, src_len, dst_addr, dst_len,
           src_port, dst_port,
    input  ready
  );
  modport sink (
    input  valid, func, index, action, src_addr, src_len, dst_addr, dst_len,
           src_port, dst_port,
    output ready
  );
endinterface

interface fmrc_res_if;
  import fmrc_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] verdict;
  logic             rule_hit;
  logic [IDX_W-1:0] hit_index;
  logic [CNT_W-1:0] hit_count;

  modport source (
    output valid, verdict, rule_hit, hit_index, hit_count,
    input  ready
  );
  modport sink (
    input  valid, verdict, rule_hit, hit_index, hit_count,
    output ready
  );
endinterface

FILE: sv/fmrc_dp.sv
// Datapath: rule and counter memories, match logic, result and output registers.
module fmrc_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  fmrc_pkg::req_t req_in,
  input  fmrc_pkg::cmd_t cmd,
  output fmrc_pkg::stat_t stat,
  output fmrc_pkg::res_t out_data,
  output logic          out_valid,
  input  logic          out_ready
);
  import fmrc_pkg::*;

  localparam logic [LEN_W-1:0] ADDR_BITS = LEN_W'(ADDR_W);

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] src_addr;
    logic [LEN_W-1:0]  src_len;
    logic [ADDR_W-1:0] dst_addr;
    logic [LEN_W-1:0]  dst_len;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
  } rule_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= ADDR_BITS) begin
      m = '1;
    end else begin
      m = {ADDR_W{1'b1}} << (ADDR_BITS - len);
    end
    return m;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    return (len > ADDR_BITS) ? ADDR_BITS : len;
  endfunction

  rule_t            rule_mem [RULE_SLOTS];
  logic [CNT_W-1:0] cnt_mem  [RULE_SLOTS];
  logic [RULE_SLOTS-1:0] valid_r;

  req_t              req_r;
  rule_t             rule_q_r;
  logic [CNT_W-1:0]  cnt_q_r;
  logic              rdq_vld_r;
  logic [SLOT_W-1:0] rdq_addr_r;
  res_t              res_r;
  res_t              res_nxt;
  res_t              out_r;
  logic              out_valid_r;

  logic [SLOT_W-1:0] req_slot;
  logic [SLOT_W-1:0] rd_addr;
  logic              in_range;
  logic [ACT_W-1:0]  act_fix;
  logic [LEN_W-1:0]  slen_c;
  logic [LEN_W-1:0]  dlen_c;
  rule_t             wr_rule;
  logic [ACT_W-1:0]  ent_act;
  logic [CNT_W-1:0]  cnt_inc;
  logic              cnt_wen;
  logic [SLOT_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic              src_ok;
  logic              dst_ok;
  logic              sport_ok;
  logic              dport_ok;

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= req_in;
    end
  end

  assign req_slot = SLOT_W'(req_r.index);
  assign in_range = CMP_W'(req_r.index) < CMP_W'(RULE_SLOTS);

  // Rule addresses are stored already cut to their prefix.
  assign act_fix = (req_r.action == ACT_RSVD) ? ACT_INVALID : req_r.action;
  assign slen_c  = clamp_len(req_r.src_len);
  assign dlen_c  = clamp_len(req_r.dst_len);
  assign wr_rule = '{action:   act_fix,
                     src_addr: req_r.src_addr & prefix_mask(slen_c),
                     src_len:  slen_c,
                     dst_addr: req_r.dst_addr & prefix_mask(dlen_c),
                     dst_len:  dlen_c,
                     src_port: req_r.src_port,
                     dst_port: req_r.dst_port};

  always_comb begin
    case (cmd.addr_sel)
      ADDR_ZERO: rd_addr = '0;
      ADDR_NEXT: rd_addr = rdq_addr_r + SLOT_W'(1);
      default:   rd_addr = req_slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rule_wr) begin
      rule_mem[req_slot] <= wr_rule;
    end
    rule_q_r <= rule_mem[rd_addr];
  end

  assign cnt_inc   = cnt_q_r + CNT_W'(1);
  assign cnt_wen   = cmd.rule_wr | cmd.cnt_wr;
  assign cnt_waddr = cmd.rule_wr ? req_slot : rdq_addr_r;
  assign cnt_wdata = cmd.rule_wr ? '0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (cnt_wen) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q_r <= cnt_mem[rd_addr];
  end

  // A slot never written reads as an invalid action.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.rule_wr) begin
      valid_r[req_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdq_vld_r  <= valid_r[rd_addr];
    rdq_addr_r <= rd_addr;
  end

  assign ent_act  = rdq_vld_r ? rule_q_r.action : ACT_INVALID;
  assign src_ok   = (rule_q_r.src_addr == '0) ||
                    ((req_r.src_addr & prefix_mask(rule_q_r.src_len)) == rule_q_r.src_addr);
  assign dst_ok   = (rule_q_r.dst_addr == '0) ||
                    ((req_r.dst_addr & prefix_mask(rule_q_r.dst_len)) == rule_q_r.dst_addr);
  assign sport_ok = (rule_q_r.src_port == '0) || (rule_q_r.src_port == req_r.src_port);
  assign dport_ok = (rule_q_r.dst_port == '0) || (rule_q_r.dst_port == req_r.dst_port);

  always_comb begin
    res_nxt = '0;
    case (cmd.res_sel)
      RES_WRITE: begin
        if (in_range) begin
          res_nxt = '{verdict: act_fix, rule_hit: 1'b0, hit_index: req_r.index,
                      hit_count: '0};
        end
      end
      RES_READ: begin
        if (in_range) begin
          res_nxt = '{verdict: ent_act, rule_hit: 1'b0, hit_index: req_r.index,
                      hit_count: cnt_q_r};
        end
      end
      RES_DEFAULT: begin
        res_nxt = '{verdict: ACT_ACCEPT, rule_hit: 1'b0, hit_index: '0, hit_count: '0};
      end
      RES_HIT: begin
        res_nxt = '{verdict: ent_act, rule_hit: 1'b1, hit_index: IDX_W'(rdq_addr_r),
                    hit_count: cnt_inc};
      end
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  assign stat = '{func:      req_r.func,
                  in_range:  in_range,
                  ent_valid: ent_act != ACT_INVALID,
                  ent_match: src_ok & dst_ok & sport_ok & dport_ok,
                  last_slot: rdq_addr_r == SLOT_W'(RULE_SLOTS - 1),
                  out_free:  !out_valid_r || out_ready};

endmodule

FILE: sv/fmrc_ctrl.sv
// Controller: sequences rule writes, entry reads and the first-match scan.
module fmrc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fmrc_pkg::stat_t stat,
  output fmrc_pkg::cmd_t  cmd
);
  import fmrc_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.addr_sel = ADDR_IDX;
    cmd.res_sel  = RES_ZERO;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.func)
          FUNC_WRITE: begin
            cmd.rule_wr  = stat.in_range;
            cmd.res_sel  = RES_WRITE;
            cmd.res_load = 1'b1;
            state_nxt    = ST_FINISH;
          end
          FUNC_READ: begin
            cmd.addr_sel = ADDR_IDX;
            state_nxt    = ST_RD_WAIT;
          end
          FUNC_LOOKUP: begin
            cmd.addr_sel = ADDR_ZERO;
            state_nxt    = ST_SCAN;
          end
          default: begin
            cmd.res_sel  = RES_ZERO;
            cmd.res_load = 1'b1;
            state_nxt    = ST_FINISH;
          end
        endcase
      end
      ST_RD_WAIT: begin
        cmd.res_sel  = RES_READ;
        cmd.res_load = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_SCAN: begin
        // The read of the next slot is issued while this one is compared.
        if (!stat.ent_valid) begin
          cmd.res_sel  = RES_DEFAULT;
          cmd.res_load = 1'b1;
          state_nxt    = ST_FINISH;
        end else if (stat.ent_match) begin
          cmd.cnt_wr   = 1'b1;
          cmd.res_sel  = RES_HIT;
          cmd.res_load = 1'b1;
          state_nxt    = ST_FINISH;
        end else if (stat.last_slot) begin
          cmd.res_sel  = RES_DEFAULT;
          cmd.res_load = 1'b1;
          state_nxt    = ST_FINISH;
        end else begin
          cmd.addr_sel = ADDR_NEXT;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/first_match_flow_rule_classifier.sv
// From request acceptance to result valid, a write passes the execute and finish states,
// a read execute, read wait and finish, and a lookup execute, one scan state and rule memory
// read per slot, and finish, which waits while the output register holds a result not yet
// taken. One request at a time; the next is taken once the result enters the output register.
// Reset (rst_n low, synchronous) returns the controller to idle, empties the output
// register and marks every rule slot invalid; no clearing pass is needed.
module first_match_flow_rule_classifier (
  input logic  clk,
  input logic  rst_n,
  fmrc_req_if.sink   in_req,
  fmrc_res_if.source out_res
);
  import fmrc_pkg::*;

  req_t  req;
  res_t  res;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  out_valid;

  assign req = '{func:     in_req.func,
                 index:    in_req.index,
                 action:   in_req.action,
                 src_addr: in_req.src_addr,
                 src_len:  in_req.src_len,
                 dst_addr: in_req.dst_addr,
                 dst_len:  in_req.dst_len,
                 src_port: in_req.src_port,
                 dst_port: in_req.dst_port};

  fmrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fmrc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_in    (req),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (res),
    .out_valid (out_valid),
    .out_ready (out_res.ready)
  );

  assign in_req.ready      = in_ready;
  assign out_res.valid     = out_valid;
  assign out_res.verdict   = res.verdict;
  assign out_res.rule_hit  = res.rule_hit;
  assign out_res.hit_index = res.hit_index;
  assign out_res.hit_count = res.hit_count;

endmodule

FILE: sv/fmrc_checker.sv
// Port-level checks of the flow rule classifier and their binding.
module fmrc_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [fmrc_pkg::ACT_W-1:0] verdict,
  input logic                   rule_hit,
  input logic [fmrc_pkg::IDX_W-1:0] hit_index,
  input logic [fmrc_pkg::CNT_W-1:0] hit_count
);
  import fmrc_pkg::*;

  // Only one request is in work at a time.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // A matching rule always carries a valid action.
  a_hit_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rule_hit |-> verdict == ACT_ACCEPT || verdict == ACT_DROP)
    else $error("rule hit with an invalid verdict");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({verdict, rule_hit, hit_index, hit_count}))
    else $error("result changed while stalled");

endmodule

bind first_match_flow_rule_classifier fmrc_checker u_fmrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .verdict   (out_res.verdict),
  .rule_hit  (out_res.rule_hit),
  .hit_index (out_res.hit_index),
  .hit_count (out_res.hit_count)
);

FILE: verif/fmrc_verdict_checker.sv
// Checker that predicts every classifier result and compares it with the result channel.
module fmrc_verdict_checker (
  input  logic clk,
  input  logic rst_n,
  fmrc_req_if  req_mon,
  fmrc_res_if  res_mon,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import fmrc_pkg::*;

  logic [ACT_W-1:0]  tbl_action   [RULE_SLOTS];
  logic [ADDR_W-1:0] tbl_src_addr [RULE_SLOTS];
  logic [LEN_W-1:0]  tbl_src_len  [RULE_SLOTS];
  logic [ADDR_W-1:0] tbl_dst_addr [RULE_SLOTS];
  logic [LEN_W-1:0]  tbl_dst_len  [RULE_SLOTS];
  logic [PORT_W-1:0] tbl_src_port [RULE_SLOTS];
  logic [PORT_W-1:0] tbl_dst_port [RULE_SLOTS];
  logic [CNT_W-1:0]  tbl_hits     [RULE_SLOTS];

  res_t expected_q[$];

  function automatic logic [ADDR_W-1:0] keep_mask(logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    if (len == 0) return '0;
    if (len >= ADDR_W) return ones;
    return ones << (ADDR_W - len);
  endfunction

  function automatic bit addr_hit(logic [ADDR_W-1:0] flow, logic [ADDR_W-1:0] rule,
                                  logic [LEN_W-1:0] len);
    return (rule == '0) || ((flow & keep_mask(len)) == rule);
  endfunction

  function automatic bit port_hit(logic [PORT_W-1:0] flow, logic [PORT_W-1:0] rule);
    return (rule == '0) || (flow == rule);
  endfunction

  // Applies one request to the shadow rule table and returns the result it gives.
  function automatic res_t classify(req_t r);
    res_t             res;
    logic [LEN_W-1:0] sl;
    logic [LEN_W-1:0] dl;
    bit               stop;
    int               i;
    res = '0;
    stop = 0;
    case (r.func)
      FUNC_WRITE: begin
        if (int'(r.index) < RULE_SLOTS) begin
          sl = (r.src_len > ADDR_W) ? LEN_W'(ADDR_W) : r.src_len;
          dl = (r.dst_len > ADDR_W) ? LEN_W'(ADDR_W) : r.dst_len;
          tbl_action[r.index]   = (r.action == ACT_RSVD) ? ACT_INVALID : r.action;
          tbl_src_len[r.index]  = sl;
          tbl_dst_len[r.index]  = dl;
          tbl_src_addr[r.index] = r.src_addr & keep_mask(sl);
          tbl_dst_addr[r.index] = r.dst_addr & keep_mask(dl);
          tbl_src_port[r.index] = r.src_port;
          tbl_dst_port[r.index] = r.dst_port;
          tbl_hits[r.index]     = '0;
          res.verdict   = tbl_action[r.index];
          res.hit_index = r.index;
        end
      end
      FUNC_LOOKUP: begin
        res.verdict = ACT_ACCEPT;
        for (i = 0; i < RULE_SLOTS; i++) begin
          if (!stop) begin
            // The first invalid slot ends the scan with the default verdict.
            if (tbl_action[i] == ACT_INVALID) begin
              stop = 1;
            end else if (addr_hit(r.src_addr, tbl_src_addr[i], tbl_src_len[i]) &&
                         addr_hit(r.dst_addr, tbl_dst_addr[i], tbl_dst_len[i]) &&
                         port_hit(r.src_port, tbl_src_port[i]) &&
                         port_hit(r.dst_port, tbl_dst_port[i])) begin
              tbl_hits[i]   = tbl_hits[i] + 1'b1;
              res.verdict   = tbl_action[i];
              res.rule_hit  = 1'b1;
              res.hit_index = IDX_W'(i);
              res.hit_count = tbl_hits[i];
              stop = 1;
            end
          end
        end
      end
      FUNC_READ: begin
        if (int'(r.index) < RULE_SLOTS) begin
          res.verdict   = tbl_action[r.index];
          res.hit_index = r.index;
          res.hit_count = tbl_hits[r.index];
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    req_t r;
    res_t got;
    res_t want;
    if (!rst_n) begin
      for (int i = 0; i < RULE_SLOTS; i++) begin
        tbl_action[i]   = ACT_INVALID;
        tbl_src_addr[i] = '0;
        tbl_src_len[i]  = '0;
        tbl_dst_addr[i] = '0;
        tbl_dst_len[i]  = '0;
        tbl_src_port[i] = '0;
        tbl_dst_port[i] = '0;
        tbl_hits[i]     = '0;
      end
      expected_q.delete();
      outstanding <= 0;
    end else begin
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) begin
        got.verdict   = res_mon.verdict;
        got.rule_hit  = res_mon.rule_hit;
        got.hit_index = res_mon.hit_index;
        got.hit_count = res_mon.hit_count;
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result: verdict %0d hit %0b index %0d count %0d",
                     $time, got.verdict, got.rule_hit, got.hit_index, got.hit_count);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.verdict !== want.verdict || got.rule_hit !== want.rule_hit ||
              got.hit_index !== want.hit_index || got.hit_count !== want.hit_count) begin
            // Fields are printed as verdict, rule hit, index and count.
            if (mismatches < 10)
              $display("%0t: result mismatch: expected %0d %0b %0d %0d, got %0d %0b %0d %0d",
                       $time, want.verdict, want.rule_hit, want.hit_index, want.hit_count,
                       got.verdict, got.rule_hit, got.hit_index, got.hit_count);
            mismatches++;
          end
        end
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        r.func     = req_mon.func;
        r.index    = req_mon.index;
        r.action   = req_mon.action;
        r.src_addr = req_mon.src_addr;
        r.src_len  = req_mon.src_len;
        r.dst_addr = req_mon.dst_addr;
        r.dst_len  = req_mon.dst_len;
        r.src_port = req_mon.src_port;
        r.dst_port = req_mon.dst_port;
        expected_q.push_back(classify(r));
      end
      outstanding <= expected_q.size();
    end
  end

endmodule

FILE: verif/first_match_flow_rule_classifier_test.sv
// Stimulus and verdict for the first-match flow rule classifier.
module first_match_flow_rule_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fmrc_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int DIRECTED_ITEMS = 24;
  localparam int RANDOM_ITEMS   = 850;
  localparam int IDLE_LIMIT     = 5000;
  localparam int TAIL_CYCLES    = RULE_SLOTS + 40;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   items_sent = 0;
  int   burst_left = 1;
  int   idle_cycles = 0;

  // What the stimulus remembers of the written rules, so lookups can be aimed at them.
  bit                sh_written [RULE_SLOTS];
  bit                sh_live    [RULE_SLOTS];
  logic [ADDR_W-1:0] sh_src     [RULE_SLOTS];
  logic [ADDR_W-1:0] sh_dst     [RULE_SLOTS];
  logic [PORT_W-1:0] sh_sport   [RULE_SLOTS];
  logic [PORT_W-1:0] sh_dport   [RULE_SLOTS];

  fmrc_req_if in_req ();
  fmrc_res_if out_res ();

  first_match_flow_rule_classifier dut (
    .clk,
    .rst_n,
    .in_req  (in_req),
    .out_res (out_res)
  );

  fmrc_verdict_checker verdict_check (
    .clk,
    .rst_n,
    .req_mon     (in_req),
    .res_mon     (out_res),
    .mismatches  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_req.valid === 1'b1 && in_req.ready === 1'b1) ||
        (out_res.valid === 1'b1 && out_res.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("first_match_flow_rule_classifier_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver alternates between short stalls, long stalls, open stretches and jitter.
  initial begin : result_sink
    int hold;
    hold = 0;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        case ($urandom_range(0, 5))
          0: begin
            out_res.ready <= 1'b0;
            hold = $urandom_range(0, 11);
          end
          1: begin
            out_res.ready <= 1'b0;
            hold = $urandom_range(12, 40);
          end
          2: begin
            out_res.ready <= 1'b1;
            hold = $urandom_range(60, 200);
          end
          default: begin
            out_res.ready <= 1'($urandom_range(0, 1));
            hold = $urandom_range(0, 6);
          end
        endcase
      end
    end
  end

  function automatic req_t mk_req(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                                  logic [ACT_W-1:0] act, logic [ADDR_W-1:0] sa,
                                  logic [LEN_W-1:0] sl, logic [ADDR_W-1:0] da,
                                  logic [LEN_W-1:0] dl, logic [PORT_W-1:0] sp,
                                  logic [PORT_W-1:0] dp);
    req_t r;
    r.func     = f;
    r.index    = idx;
    r.action   = act;
    r.src_addr = sa;
    r.src_len  = sl;
    r.dst_addr = da;
    r.dst_len  = dl;
    r.src_port = sp;
    r.dst_port = dp;
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return LEN_W'($urandom_range(33, 63));
      2, 3, 4: return LEN_W'($urandom_range(1, 7));
      default: return LEN_W'($urandom_range(8, 32));
    endcase
  endfunction

  function automatic req_t random_rule(int idx, bit need_sport, bit any_action);
    logic [ACT_W-1:0]  act;
    logic [PORT_W-1:0] sp;
    logic [PORT_W-1:0] dp;
    act = ($urandom_range(0, 1) != 0) ? ACT_DROP : ACT_ACCEPT;
    if (any_action) act = ACT_W'($urandom_range(0, 3));
    sp = PORT_W'($urandom_range(1, 65535));
    if (!need_sport && $urandom_range(0, 3) == 0) sp = '0;
    dp = ($urandom_range(0, 3) == 0) ? '0 : PORT_W'($urandom);
    return mk_req(FUNC_WRITE, IDX_W'(idx), act, ADDR_W'($urandom), pick_len(),
                  ADDR_W'($urandom), pick_len(), sp, dp);
  endfunction

  function automatic req_t random_flow();
    return mk_req(FUNC_LOOKUP, IDX_W'($urandom), ACT_W'($urandom), ADDR_W'($urandom),
                  LEN_W'($urandom), ADDR_W'($urandom), LEN_W'($urandom),
                  PORT_W'($urandom), PORT_W'($urandom));
  endfunction

  // A flow built from a stored rule, sometimes nudged by a bit or a new source port so it may just miss.
  function automatic req_t flow_for_slot(int j);
    logic [ADDR_W-1:0] sa;
    logic [ADDR_W-1:0] da;
    logic [PORT_W-1:0] sp;
    logic [PORT_W-1:0] dp;
    int                k;
    sa = sh_src[j];
    da = sh_dst[j];
    if ($urandom_range(0, 4) == 0) sa[0] = ~sa[0];
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, ADDR_W - 1);
      da[k] = ~da[k];
    end
    sp = (sh_sport[j] == '0) ? PORT_W'($urandom) : sh_sport[j];
    dp = (sh_dport[j] == '0) ? PORT_W'($urandom) : sh_dport[j];
    if ($urandom_range(0, 9) == 0) sp = PORT_W'($urandom);
    return mk_req(FUNC_LOOKUP, IDX_W'($urandom), ACT_W'($urandom), sa, LEN_W'($urandom),
                  da, LEN_W'($urandom), sp, dp);
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    in_req.valid    <= 1'b1;
    in_req.func     <= r.func;
    in_req.index    <= r.index;
    in_req.action   <= r.action;
    in_req.src_addr <= r.src_addr;
    in_req.src_len  <= r.src_len;
    in_req.dst_addr <= r.dst_addr;
    in_req.dst_len  <= r.dst_len;
    in_req.src_port <= r.src_port;
    in_req.dst_port <= r.dst_port;
    @(posedge clk);
    while (in_req.ready !== 1'b1) @(posedge clk);
    items_sent++;
    if (r.func == FUNC_WRITE) begin
      sh_written[r.index] = 1'b1;
      sh_live[r.index]    = (r.action == ACT_ACCEPT || r.action == ACT_DROP);
      sh_src[r.index]     = r.src_addr;
      sh_dst[r.index]     = r.dst_addr;
      sh_sport[r.index]   = r.src_port;
      sh_dport[r.index]   = r.dst_port;
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One request of the random mix; slots up to hi are the ones its lookups and writes aim at.
  task automatic random_op(int hi);
    int sel;
    int j;
    int k;
    int idx;
    sel = $urandom_range(0, 99);
    j = -1;
    if (sel < 58) begin
      for (k = 0; k < 16 && j < 0; k++) begin
        idx = $urandom_range(0, hi);
        if (sh_live[idx]) j = idx;
      end
      send_req((j >= 0) ? flow_for_slot(j) : random_flow());
    end else if (sel < 70) begin
      send_req(random_flow());
    end else if (sel < 84) begin
      // Only slots that were written are read back.
      for (k = 0; k < 16 && j < 0; k++) begin
        idx = $urandom_range(0, RULE_SLOTS - 1);
        if (sh_written[idx]) j = idx;
      end
      if (j >= 0)
        send_req(mk_req(FUNC_READ, IDX_W'(j), ACT_W'($urandom), ADDR_W'($urandom),
                        LEN_W'($urandom), ADDR_W'($urandom), LEN_W'($urandom),
                        PORT_W'($urandom), PORT_W'($urandom)));
      else
        send_req(random_flow());
    end else if (sel < 97) begin
      send_req(random_rule($urandom_range(0, hi), 1'b0, 1'b1));
    end else begin
      send_req(mk_req(FUNC_UNUSED, IDX_W'($urandom), ACT_W'($urandom), ADDR_W'($urandom),
                      LEN_W'($urandom), ADDR_W'($urandom), LEN_W'($urandom),
                      PORT_W'($urandom), PORT_W'($urandom)));
    end
  endtask

  initial begin : stimulus
    int n;
    int m;
    int k;
    int phase_no;
    rst_n           <= 1'b0;
    in_req.valid    <= 1'b0;
    in_req.func     <= '0;
    in_req.index    <= '0;
    in_req.action   <= '0;
    in_req.src_addr <= '0;
    in_req.src_len  <= '0;
    in_req.dst_addr <= '0;
    in_req.dst_len  <= '0;
    in_req.src_port <= '0;
    in_req.dst_port <= '0;
    for (k = 0; k < RULE_SLOTS; k++) begin
      sh_written[k] = 1'b0;
      sh_live[k]    = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, then the unused function code.
    send_req(mk_req(FUNC_LOOKUP, 8'd0, ACT_INVALID, 32'h0A000001, 6'd0, 32'h0A000002, 6'd0,
                    16'd1, 16'd2));
    send_req(mk_req(FUNC_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1));
    send_req(mk_req(FUNC_WRITE, 8'd0, ACT_ACCEPT, 32'hC0A80155, 6'd24, 32'h0, 6'd0,
                    16'd0, 16'd80));
    // Length above 32 saturates; all-ones fields.
    send_req(mk_req(FUNC_WRITE, 8'd1, ACT_DROP, 32'hFFFFFFFF, 6'd63, 32'hFFFFFFFF, 6'd32,
                    16'hFFFF, 16'hFFFF));
    // Length zero masks the source address away entirely.
    send_req(mk_req(FUNC_WRITE, 8'd2, ACT_DROP, 32'h12345678, 6'd0, 32'h0A0B0C0D, 6'd8,
                    16'd1234, 16'd0));
    send_req(mk_req(FUNC_LOOKUP, 8'd0, ACT_INVALID, 32'hC0A801FF, 6'd0, 32'h01020304, 6'd0,
                    16'd5555, 16'd80));
    send_req(mk_req(FUNC_LOOKUP, 8'd0, ACT_INVALID, 32'hC0A801FF, 6'd0, 32'h01020304, 6'd0,
                    16'd5555, 16'd80));
    send_req(mk_req(FUNC_LOOKUP, 8'd0, ACT_INVALID, '1, 6'd0, '1, 6'd0, '1, '1));
    send_req(mk_req(FUNC_LOOKUP, 8'd0, ACT_INVALID, 32'h0, 6'd0, 32'h0AFFFFFF, 6'd0,
                    16'd1234, 16'd7));
    send_req(mk_req(FUNC_LOOKUP, 8'd0, ACT_INVALID, 32'h0, 6'd0, 32'h0, 6'd0, 16'd1, 16'd1));
    send_req(mk_req(FUNC_READ, 8'd0, ACT_INVALID, '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FUNC_READ, 8'd1, ACT_INVALID, '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FUNC_READ, 8'd2, ACT_INVALID, '0, '0, '0, '0, '0, '0));
    // The reserved action code is stored as invalid.
    send_req(mk_req(FUNC_WRITE, 8'd3, ACT_RSVD, 32'h55555555, 6'd16, 32'hAAAAAAAA, 6'd16,
                    16'd9, 16'd9));
    send_req(mk_req(FUNC_READ, 8'd3, ACT_INVALID, '0, '0, '0, '0, '0, '0));
    send_req(mk_req(FUNC_WRITE, 8'd3, ACT_ACCEPT, '0, 6'd0, '0, 6'd0, 16'd0, 16'd0));
    send_req(mk_req(FUNC_LOOKUP, 8'd0, ACT_INVALID, 32'h0, 6'd0, 32'h0, 6'd0, 16'd1, 16'd1));
    send_req(mk_req(FUNC_WRITE, 8'd255, ACT_DROP, 32'h80000000, 6'd1, 32'h00000001, 6'd32,
                    16'd65535, 16'd1));
    send_req(mk_req(FUNC_READ, 8'd255, ACT_INVALID, '1, '1, '1, '1, '1, '1));
    // An invalid slot early in the table cuts the scan short.
    send_req(mk_req(FUNC_WRITE, 8'd1, ACT_INVALID, '1, 6'd32, '1, 6'd32, '1, '1));
    send_req(mk_req(FUNC_LOOKUP, 8'd0, ACT_INVALID, '1, 6'd0, '1, 6'd0, '1, '1));
    send_req(mk_req(FUNC_READ, 8'd1, ACT_INVALID, '0, '0, '0, '0, '0, '0));
    // A zero rule address is a wildcard even at full length.
    send_req(mk_req(FUNC_WRITE, 8'd0, ACT_ACCEPT, 32'h0, 6'd32, 32'h0, 6'd32, 16'd0, 16'd0));
    send_req(mk_req(FUNC_LOOKUP, 8'd0, ACT_INVALID, 32'hDEADBEEF, 6'd0, 32'h01020304, 6'd0,
                    16'd22, 16'd443));
    wait_drained();

    phase_no = 0;
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      if (phase_no == 2) begin
        // Every slot holds a rule with a nonzero source port, so a flow with source port
        // zero runs the whole table without a match.
        for (k = 0; k < RULE_SLOTS; k++) send_req(random_rule(k, 1'b1, 1'b0));
        repeat (24) begin
          if ($urandom_range(0, 1) != 0)
            send_req(mk_req(FUNC_LOOKUP, IDX_W'($urandom), ACT_W'($urandom),
                            ADDR_W'($urandom), LEN_W'($urandom), ADDR_W'($urandom),
                            LEN_W'($urandom), '0, PORT_W'($urandom)));
          else
            send_req(flow_for_slot($urandom_range(200, RULE_SLOTS - 1)));
        end
        wait_drained();
      end else begin
        n = $urandom_range(2, 48);
        for (k = 0; k < n; k++) send_req(random_rule(k, 1'b0, 1'b0));
        if ($urandom_range(0, 1) != 0) send_req(random_rule(n, 1'b0, 1'b1));
        m = $urandom_range(10, 40);
        repeat (m) random_op(($urandom_range(0, 5) == 0) ? RULE_SLOTS - 1 : n);
        if ($urandom_range(0, 1) != 0) wait_drained();
      end
      phase_no++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("first_match_flow_rule_classifier_test passed");
    end else begin
      $display("first_match_flow_rule_classifier_test failed");
    end
    $finish;
  end

endmodule
